// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the checker module of the RTL folder.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("Assertion failed: implication does not hold.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed: next-cycle implication does not hold.");

`endif

// ===== hw/rtl/fts_pkg.sv =====
// Package of the file type sniffer: sizes, class codes, signature table and shared types.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package fts_pkg;

  localparam int BLOCK_BYTES = 1024;
  localparam int CNT_W       = $clog2(BLOCK_BYTES + 1);
  localparam int PCT_W       = 7;
  localparam int PROD_W      = CNT_W + PCT_W + 1;
  localparam int PCT_SCALE   = 100;

  localparam int CLASS_W  = 5;
  localparam int NUM_SIGS = 18;

  localparam logic [CLASS_W-1:0] CLASS_SHELL   = CLASS_W'(18);
  localparam logic [CLASS_W-1:0] CLASS_C       = CLASS_W'(19);
  localparam logic [CLASS_W-1:0] CLASS_ENGLISH = CLASS_W'(20);
  localparam logic [CLASS_W-1:0] CLASS_ASCII   = CLASS_W'(21);
  localparam logic [CLASS_W-1:0] CLASS_DATA    = CLASS_W'(22);
  localparam logic [CLASS_W-1:0] CLASS_EMPTY   = CLASS_W'(23);

  localparam logic [CLASS_W-1:0] CLASS_EXEC_FIRST = CLASS_W'(11);
  localparam logic [CLASS_W-1:0] CLASS_EXEC_LAST  = CLASS_W'(14);
  localparam logic [CLASS_W-1:0] CLASS_CORE       = CLASS_W'(17);

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_CODE_CUTOFF    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_ENGLISH_CUTOFF = CFG_IDX_W'(1);
  localparam logic [PCT_W-1:0] CODE_CUTOFF_RESET    = PCT_W'(1);
  localparam logic [PCT_W-1:0] ENGLISH_CUTOFF_RESET = PCT_W'(25);

  localparam logic [CNT_W-1:0] POS_SYM_LO_FIRST = CNT_W'(16);
  localparam logic [CNT_W-1:0] POS_SYM_LO_LAST  = CNT_W'(19);
  localparam logic [CNT_W-1:0] POS_SYM_HI_FIRST = CNT_W'(28);
  localparam logic [CNT_W-1:0] POS_SYM_HI_LAST  = CNT_W'(31);
  localparam logic [CNT_W-1:0] POS_CORE_CPU     = CNT_W'(36);
  localparam logic [CNT_W-1:0] POS_HEADER_END   = CNT_W'(4);

  localparam logic [7:0] CPU_BYTE_I86  = 8'h01;
  localparam logic [7:0] CPU_BYTE_I386 = 8'h02;
  localparam logic [1:0] CPU_UNKNOWN   = 2'd0;
  localparam logic [1:0] CPU_I86       = 2'd1;
  localparam logic [1:0] CPU_I386      = 2'd2;

  typedef enum logic [1:0] {
    KIND_PLAIN,
    KIND_EXEC,
    KIND_EXEC_ALT,
    KIND_CORE
  } sig_kind_e;

  // Signatures hold byte 0 of the file in bits 7:0.
  localparam logic [31:0] SIG_MAGIC [NUM_SIGS] = '{
    32'h008D9D1F, 32'h00909D1F, 32'h0000FF65, 32'h0000FF2C, 32'h0000FF65,
    32'h20756E47, 32'h72613C21, 32'h00000201, 32'h000086A3, 32'h07010000,
    32'h00000107, 32'h04000301, 32'h10000301, 32'h01031004, 32'h0B100301,
    32'h0000010B, 32'h010B0000, 32'hC0C41282
  };

  localparam logic [31:0] SIG_MASK [NUM_SIGS] = '{
    32'h00FFFFFF, 32'h00FFFFFF, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'h0000FFFF, 32'h0000FFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFF00FFFF, 32'hFF00FFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
    32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF
  };

  localparam sig_kind_e SIG_KIND [NUM_SIGS] = '{
    KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN,
    KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN, KIND_PLAIN,
    KIND_EXEC, KIND_EXEC, KIND_EXEC, KIND_EXEC,
    KIND_EXEC_ALT, KIND_EXEC_ALT, KIND_CORE
  };

  typedef struct packed {
    logic [31:0]      header_word;
    logic             sym_lo_nz;
    logic             sym_hi_nz;
    logic [7:0]       core_byte;
    logic [CNT_W-1:0] byte_count;
    logic             high_bit;
    logic [CNT_W-1:0] punct_count;
    logic [CNT_W-1:0] letter_count;
  } file_state_t;

  typedef struct packed {
    file_state_t st;
    logic        exec;
    logic        empty;
  } snap_t;

  typedef struct packed {
    logic [CLASS_W-1:0] file_class;
    logic               uzp_flag;
    logic               pal_flag;
    logic               nsym_flag;
    logic               separate_id;
    logic               not_stripped;
    logic [1:0]         core_cpu;
  } result_t;

endpackage

// ===== hw/rtl/fts_collect.sv =====
// Per-byte collection stage: header bytes, symbol marks, counters and the file snapshot.
// Depends on fts_pkg.
`timescale 1ns / 1ps

module fts_collect import fts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       empty_file_i,
  input  logic       exec_bits_i,
  output snap_t      snap_o,
  output logic       snap_valid_o,
  input  logic       snap_take_i
);

  file_state_t state_q, state_d, state_next;
  snap_t       snap_q;
  logic        snap_valid_q, snap_valid_d;
  logic        accept, finish;
  logic [CNT_W-1:0] pos;
  logic [7:0]  lower;
  logic        is_punct, is_letter;

  assign in_stall_o = snap_valid_q && !snap_take_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign finish     = last_byte_i || empty_file_i;
  assign pos        = state_q.byte_count;

  assign lower = (data_byte_i >= "A" && data_byte_i <= "Z") ? (data_byte_i | 8'h20)
                                                             : data_byte_i;
  assign is_punct = (data_byte_i == ";") || (data_byte_i == "{") || (data_byte_i == "}") ||
                    (data_byte_i == "#") || (data_byte_i == "*") || (data_byte_i == "<") ||
                    (data_byte_i == ">") || (data_byte_i == "/");
  assign is_letter = (lower == "e") || (lower == "t") || (lower == "a") || (lower == "o") ||
                     (lower == "i") || (lower == "n") || (lower == "s");

  always_comb begin
    state_next = state_q;
    if (pos < CNT_W'(BLOCK_BYTES)) begin
      if (pos < POS_HEADER_END) begin
        state_next.header_word[8*pos[1:0] +: 8] = data_byte_i;
      end
      if (pos >= POS_SYM_LO_FIRST && pos <= POS_SYM_LO_LAST && data_byte_i != 8'h00) begin
        state_next.sym_lo_nz = 1'b1;
      end
      if (pos >= POS_SYM_HI_FIRST && pos <= POS_SYM_HI_LAST && data_byte_i != 8'h00) begin
        state_next.sym_hi_nz = 1'b1;
      end
      if (pos == POS_CORE_CPU) begin
        state_next.core_byte = data_byte_i;
      end
      if (data_byte_i[7]) begin
        state_next.high_bit = 1'b1;
      end
      if (is_punct) begin
        state_next.punct_count = state_q.punct_count + CNT_W'(1);
      end
      if (is_letter) begin
        state_next.letter_count = state_q.letter_count + CNT_W'(1);
      end
      state_next.byte_count = pos + CNT_W'(1);
    end
  end

  always_comb begin
    state_d      = state_q;
    snap_valid_d = snap_valid_q && !snap_take_i;
    if (accept) begin
      state_d = finish ? '0 : state_next;
      if (finish) begin
        snap_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= '0;
      snap_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      snap_valid_q <= snap_valid_d;
    end
  end

  // A file marked empty drops whatever was collected and classifies as empty.
  always_ff @(posedge clk_i) begin
    if (accept && finish) begin
      snap_q.st    <= empty_file_i ? '0 : state_next;
      snap_q.exec  <= exec_bits_i;
      snap_q.empty <= empty_file_i;
    end
  end

  assign snap_o       = snap_q;
  assign snap_valid_o = snap_valid_q;

endmodule

// ===== hw/rtl/fts_classify.sv =====
// Classification stage: signature match, percentage tests, result register and cutoff registers.
// Depends on fts_pkg.
`timescale 1ns / 1ps

module fts_classify import fts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  snap_t                 snap_i,
  input  logic                  snap_valid_i,
  output logic                  snap_take_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output result_t               result_o,
  output logic                  out_valid_o,
  input  logic                  out_stall_i
);

  logic [PCT_W-1:0]   code_cut_q, english_cut_q;
  logic               out_valid_q;
  result_t            res_q, res_d;
  logic               hit;
  logic [CLASS_W-1:0] hit_idx;
  logic [7:0]         byte2;
  logic [PROD_W-1:0]  punct_scaled, letter_scaled, code_limit, english_limit;
  logic               code_above, english_above;

  assign cfg_ready_o = 1'b1;
  assign snap_take_o = !out_valid_q || !out_stall_i;

  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = NUM_SIGS - 1; i >= 0; i--) begin
      if ((snap_i.st.header_word & SIG_MASK[i]) == SIG_MAGIC[i]) begin
        hit     = 1'b1;
        hit_idx = CLASS_W'(i);
      end
    end
  end

  assign byte2 = snap_i.st.header_word[23:16];

  // The integer percentage exceeds the cutoff exactly when 100*count >= (cutoff+1)*bytes.
  assign punct_scaled  = PROD_W'(snap_i.st.punct_count) * PROD_W'(PCT_SCALE);
  assign letter_scaled = PROD_W'(snap_i.st.letter_count) * PROD_W'(PCT_SCALE);
  assign code_limit    = (PROD_W'(code_cut_q) + PROD_W'(1)) * PROD_W'(snap_i.st.byte_count);
  assign english_limit = (PROD_W'(english_cut_q) + PROD_W'(1)) *
                         PROD_W'(snap_i.st.byte_count);
  assign code_above    = punct_scaled >= code_limit;
  assign english_above = letter_scaled >= english_limit;

  always_comb begin
    res_d = '0;
    if (snap_i.empty) begin
      res_d.file_class = CLASS_EMPTY;
    end else if (hit) begin
      res_d.file_class = hit_idx;
      unique case (SIG_KIND[hit_idx])
        KIND_EXEC: begin
          res_d.uzp_flag     = byte2[0];
          res_d.pal_flag     = byte2[1];
          res_d.nsym_flag    = byte2[2];
          res_d.separate_id  = byte2[5];
          res_d.not_stripped = snap_i.st.sym_hi_nz;
        end
        KIND_EXEC_ALT: begin
          res_d.not_stripped = snap_i.st.sym_lo_nz;
        end
        KIND_CORE: begin
          if (snap_i.st.core_byte == CPU_BYTE_I86) begin
            res_d.core_cpu = CPU_I86;
          end else if (snap_i.st.core_byte == CPU_BYTE_I386) begin
            res_d.core_cpu = CPU_I386;
          end else begin
            res_d.core_cpu = CPU_UNKNOWN;
          end
        end
        default: begin
          res_d.core_cpu = CPU_UNKNOWN;
        end
      endcase
    end else if (snap_i.exec) begin
      res_d.file_class = CLASS_SHELL;
    end else if (snap_i.st.high_bit || snap_i.st.byte_count == '0) begin
      res_d.file_class = CLASS_DATA;
    end else if (code_above) begin
      res_d.file_class = CLASS_C;
    end else if (english_above) begin
      res_d.file_class = CLASS_ENGLISH;
    end else begin
      res_d.file_class = CLASS_ASCII;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      code_cut_q    <= CODE_CUTOFF_RESET;
      english_cut_q <= ENGLISH_CUTOFF_RESET;
    end else begin
      if (snap_take_o) begin
        out_valid_q <= snap_valid_i;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_CODE_CUTOFF) begin
          code_cut_q <= cfg_data_i[PCT_W-1:0];
        end else if (cfg_index_i == REG_ENGLISH_CUTOFF) begin
          english_cut_q <= cfg_data_i[PCT_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (snap_take_o && snap_valid_i) begin
      res_q <= res_d;
    end
  end

  assign result_o    = res_q;
  assign out_valid_o = out_valid_q;

endmodule

// ===== hw/rtl/file_type_sniffer_unit.sv =====
// Top level of the file type sniffer: byte collection stage followed by classification stage.
// Depends on fts_pkg, fts_collect and fts_classify.
`timescale 1ns / 1ps
//
// Channel   Direction  Handshake                Payload
// in        input      in_valid_i / in_stall_o  data_byte_i, last_byte_i, empty_file_i,
//                                               exec_bits_i
// out       output     out_valid_o/out_stall_i  file_class_o and the flag and cpu fields
// cfg       input      cfg_valid_i/cfg_ready_o  cfg_index_i, cfg_data_i
//
// One byte is taken per cycle while in_stall_o is low; the collection counters update in
// the cycle of the transfer. A last or empty byte yields its result through the snapshot
// register and then the result register, while the following bytes keep streaming.
// Reset clears the collected file state and restores the cutoff registers to 1 and 25.
// A stalled output holds its result; the input stalls only when both registers are full.

module file_type_sniffer_unit import fts_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  empty_file_i,
  input  logic                  exec_bits_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [CLASS_W-1:0]    file_class_o,
  output logic                  uzp_flag_o,
  output logic                  pal_flag_o,
  output logic                  nsym_flag_o,
  output logic                  separate_id_o,
  output logic                  not_stripped_o,
  output logic [1:0]            core_cpu_o,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  snap_t   snap;
  logic    snap_valid, snap_take;
  result_t result;

  fts_collect u_collect (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .data_byte_i  (data_byte_i),
    .last_byte_i  (last_byte_i),
    .empty_file_i (empty_file_i),
    .exec_bits_i  (exec_bits_i),
    .snap_o       (snap),
    .snap_valid_o (snap_valid),
    .snap_take_i  (snap_take)
  );

  fts_classify u_classify (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .snap_i       (snap),
    .snap_valid_i (snap_valid),
    .snap_take_o  (snap_take),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .result_o     (result),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i)
  );

  assign file_class_o   = result.file_class;
  assign uzp_flag_o     = result.uzp_flag;
  assign pal_flag_o     = result.pal_flag;
  assign nsym_flag_o    = result.nsym_flag;
  assign separate_id_o  = result.separate_id;
  assign not_stripped_o = result.not_stripped;
  assign core_cpu_o     = result.core_cpu;

endmodule

// ===== hw/rtl/fts_checker.sv =====
// Port-level checker of the file type sniffer, attached to the top level by a bind.
// Depends on fts_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fts_port_checker import fts_pkg::*; (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input logic [CLASS_W-1:0]    file_class_o,
  input logic                  uzp_flag_o,
  input logic                  pal_flag_o,
  input logic                  nsym_flag_o,
  input logic                  separate_id_o,
  input logic                  not_stripped_o,
  input logic [1:0]            core_cpu_o
);

  logic [CLASS_W+6:0] out_word;
  logic               flags_any;
  logic               exec_class;

  assign out_word   = {file_class_o, uzp_flag_o, pal_flag_o, nsym_flag_o, separate_id_o,
                       not_stripped_o, core_cpu_o};
  assign flags_any  = uzp_flag_o || pal_flag_o || nsym_flag_o || separate_id_o;
  assign exec_class = file_class_o >= CLASS_EXEC_FIRST && file_class_o <= CLASS_EXEC_LAST;

  `ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(out_word))
  `ASSERT_IMPLY(a_cpu_only_core, clk_i, rst_ni, out_valid_o && core_cpu_o != CPU_UNKNOWN, file_class_o == CLASS_CORE)
  `ASSERT_IMPLY(a_flags_only_exec, clk_i, rst_ni, out_valid_o && flags_any, exec_class)
  `ASSERT_IMPLY(a_stall_needs_full, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

endmodule

bind file_type_sniffer_unit fts_port_checker u_fts_checker (.*);
